@@ hdl/trajectory_feedforward_assert.svh @@
// assertion macros for the trajectory feedforward block
// expects clk and arst_n in the scope where the macros are used
`ifndef TRAJECTORY_FEEDFORWARD_ASSERT_SVH
`define TRAJECTORY_FEEDFORWARD_ASSERT_SVH

// same-cycle implication
`define TFF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TFF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/tff_pkg.sv @@
// shared types and constants of the trajectory feedforward block
// no dependencies
`default_nettype none

package tff_pkg;

	localparam int NAX      = 2;
	localparam int AXES_DEF = 2;
	localparam int SP_W     = 32;
	localparam int PER_W    = 16;
	localparam int DIV_W    = 55;
	localparam int ACC_W    = 88;
	localparam int MAC_STEPS = 6;
	localparam int CNT_W    = $clog2(DIV_W);

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_ZERO_PER = 2'd1,
		STAT_SAT      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CFG_POS_AX0 = 3'd0,
		CFG_VEL_AX0 = 3'd1,
		CFG_ACC_AX0 = 3'd2,
		CFG_POS_AX1 = 3'd3,
		CFG_VEL_AX1 = 3'd4,
		CFG_ACC_AX1 = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic take;
	} lane_ctl_t;

	typedef struct packed {
		logic                   done;
		logic                   sat;
		logic signed [SP_W-1:0] drive;
	} lane_stat_t;

	function automatic logic [SP_W-1:0] mag32(input logic signed [SP_W-1:0] v);
		return v[SP_W-1] ? SP_W'(-v) : SP_W'(v);
	endfunction

endpackage

`default_nettype wire

@@ hdl/tff_lane.sv @@
// one axis: setpoint history, finite differences, dividers and gain mac
// uses tff_pkg
`default_nettype none

module tff_lane (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tff_pkg::lane_ctl_t          ctl,
	input  wire logic signed [31:0]          setpoint,
	input  wire logic signed [31:0]          gain_pos,
	input  wire logic signed [31:0]          gain_vel,
	input  wire logic signed [31:0]          gain_acc,
	input  wire logic [tff_pkg::PER_W-1:0]   per,
	input  wire logic [2*tff_pkg::PER_W-1:0] per_sq,
	output tff_pkg::lane_stat_t              stat
);

	typedef enum logic [5:0] {
		L_IDLE  = 6'b000001,
		L_DIFF  = 6'b000010,
		L_SCALE = 6'b000100,
		L_DIV   = 6'b001000,
		L_MAC   = 6'b010000,
		L_DONE  = 6'b100000
	} lstate_t;

	localparam int DW = tff_pkg::DIV_W;
	localparam int AW = tff_pkg::ACC_W;
	localparam int PW = tff_pkg::PER_W;
	localparam int CW = tff_pkg::CNT_W;
	localparam logic [tff_pkg::CNT_W-1:0] DIV_LAST = tff_pkg::CNT_W'(DW - 1);
	localparam logic [tff_pkg::CNT_W-1:0] MAC_LAST = tff_pkg::CNT_W'(tff_pkg::MAC_STEPS - 1);
	localparam logic [CW-1:0] M_POS    = CW'(0);
	localparam logic [CW-1:0] M_VEL_LO = CW'(1);
	localparam logic [CW-1:0] M_VEL_HI = CW'(2);
	localparam logic [CW-1:0] M_ACC_LO = CW'(3);
	localparam logic [CW-1:0] M_ACC_HI = CW'(4);

	lstate_t                     state_q;
	logic [tff_pkg::CNT_W-1:0]   cnt_q;
	logic signed [31:0]          d_q, d1_q, d2_q, last_q, older_q;
	logic signed [32:0]          vdiff_q;
	logic signed [34:0]          adiff_q;
	logic                        vneg_q, aneg_q;
	logic [DW-1:0]               vnum_q, anum_q;
	logic [PW-1:0]               vrem_q;
	logic [2*PW-1:0]             arem_q;
	logic [63:0]                 prod_s1;
	logic                        neg_s1, hi_s1;
	logic signed [AW-1:0]        acc_q;

	logic signed [43:0] vprod;
	logic signed [55:0] aprod;
	logic [43:0]        vmag;
	logic [55:0]        amag;
	logic [PW:0]        vr, vsub;
	logic [2*PW:0]      ar, asub;
	logic               vge, age;
	logic [31:0]        mg, mx;
	logic               mneg, mhi;
	logic [AW-1:0]      term;
	logic               fit;

	assign vprod = 44'(vdiff_q) * 44'sd1000;
	assign aprod = 56'(adiff_q) * 56'sd1000000;
	assign vmag  = vprod[43] ? 44'(-vprod) : 44'(vprod);
	assign amag  = aprod[55] ? 56'(-aprod) : 56'(aprod);

	// restoring division, one quotient bit per cycle
	assign vr   = {vrem_q, vnum_q[DW-1]};
	assign vsub = vr - {1'b0, per};
	assign vge  = vr >= {1'b0, per};
	assign ar   = {arem_q, anum_q[DW-1]};
	assign asub = ar - {1'b0, per_sq};
	assign age  = ar >= {1'b0, per_sq};

	// mac operand select: quotients split into low 32 and high bits
	always_comb begin
		mg = '0;
		mx = '0;
		mneg = 1'b0;
		mhi = 1'b0;
		case (cnt_q)
			M_POS: begin
				mg = tff_pkg::mag32(gain_pos);
				mx = tff_pkg::mag32(d_q);
				mneg = gain_pos[31] ^ d_q[31];
			end
			M_VEL_LO: begin
				mg = tff_pkg::mag32(gain_vel);
				mx = vnum_q[31:0];
				mneg = gain_vel[31] ^ vneg_q;
			end
			M_VEL_HI: begin
				mg = tff_pkg::mag32(gain_vel);
				mx = 32'(vnum_q[DW-1:32]);
				mneg = gain_vel[31] ^ vneg_q;
				mhi = 1'b1;
			end
			M_ACC_LO: begin
				mg = tff_pkg::mag32(gain_acc);
				mx = anum_q[31:0];
				mneg = gain_acc[31] ^ aneg_q;
			end
			M_ACC_HI: begin
				mg = tff_pkg::mag32(gain_acc);
				mx = 32'(anum_q[DW-1:32]);
				mneg = gain_acc[31] ^ aneg_q;
				mhi = 1'b1;
			end
			default: begin
				mg = '0;
			end
		endcase
	end

	assign term = hi_s1 ? (AW'(prod_s1) << 32) : AW'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			cnt_q   <= '0;
			last_q  <= '0;
			older_q <= '0;
		end else begin
			if (ctl.clear) begin
				last_q  <= '0;
				older_q <= '0;
			end
			case (state_q)
				L_IDLE: begin
					if (ctl.start) begin
						state_q <= L_DIFF;
					end
				end
				L_DIFF: begin
					state_q <= L_SCALE;
				end
				L_SCALE: begin
					cnt_q   <= '0;
					state_q <= L_DIV;
				end
				L_DIV: begin
					if (cnt_q == DIV_LAST) begin
						cnt_q   <= '0;
						state_q <= L_MAC;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				L_MAC: begin
					if (cnt_q == MAC_LAST) begin
						cnt_q   <= '0;
						state_q <= L_DONE;
						older_q <= d1_q;
						last_q  <= d_q;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				L_DONE: begin
					if (ctl.take) begin
						state_q <= L_IDLE;
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (ctl.start) begin
					d_q  <= setpoint;
					d1_q <= ctl.clear ? '0 : last_q;
					d2_q <= ctl.clear ? '0 : older_q;
				end
			end
			L_DIFF: begin
				vdiff_q <= 33'(d_q) - 33'(d1_q);
				adiff_q <= 35'(d_q) - 35'(d1_q) - 35'(d1_q) + 35'(d2_q);
			end
			L_SCALE: begin
				vneg_q <= vprod[43];
				aneg_q <= aprod[55];
				vnum_q <= DW'(vmag);
				anum_q <= amag[DW-1:0];
				vrem_q <= '0;
				arem_q <= '0;
			end
			L_DIV: begin
				vnum_q <= {vnum_q[DW-2:0], vge};
				vrem_q <= vge ? vsub[PW-1:0] : vr[PW-1:0];
				anum_q <= {anum_q[DW-2:0], age};
				arem_q <= age ? asub[2*PW-1:0] : ar[2*PW-1:0];
			end
			L_MAC: begin
				prod_s1 <= 64'(mg) * 64'(mx);
				neg_s1  <= mneg;
				hi_s1   <= mhi;
				if (cnt_q == '0) begin
					acc_q <= '0;
				end else if (neg_s1) begin
					acc_q <= acc_q - $signed(term);
				end else begin
					acc_q <= acc_q + $signed(term);
				end
			end
			default: begin
			end
		endcase
	end

	// fits after the floor shift by 16 when bits 87..47 agree
	assign fit = (acc_q[AW-1:47] == '0) || (acc_q[AW-1:47] == '1);

	always_comb begin
		stat.done  = (state_q == L_DONE);
		stat.sat   = !fit;
		stat.drive = fit ? acc_q[47:16] : (acc_q[AW-1] ? 32'sh80000000 : 32'sh7fffffff);
	end

endmodule

`default_nettype wire

@@ hdl/tff_merge.sv @@
// merging stage: gathers the lane results into the output register
// uses tff_pkg
`default_nettype none

module tff_merge (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire logic                zero,
	input  wire tff_pkg::lane_stat_t stat [tff_pkg::NAX],
	input  wire logic                m_tready,
	output logic                     m_tvalid,
	output logic [tff_pkg::NAX*32-1:0] m_tdata,
	output logic [1:0]               m_tuser,
	output logic                     can_load
);

	logic                         valid_q;
	logic [tff_pkg::NAX*32-1:0]   data_q;
	tff_pkg::status_t             user_q;
	logic [tff_pkg::NAX*32-1:0]   data_d;
	logic                         any_sat;

	always_comb begin
		data_d  = '0;
		any_sat = 1'b0;
		for (int a = 0; a < tff_pkg::NAX; a++) begin
			data_d[a*32 +: 32] = stat[a].drive;
			any_sat = any_sat | stat[a].sat;
		end
	end

	assign can_load = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (zero) begin
				data_q <= '0;
				user_q <= tff_pkg::STAT_ZERO_PER;
			end else begin
				data_q <= data_d;
				user_q <= any_sat ? tff_pkg::STAT_SAT : tff_pkg::STAT_OK;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

endmodule

`default_nettype wire

@@ hdl/trajectory_feedforward.sv @@
// Velocity and acceleration feedforward per axis from setpoint finite differences.
// An item with a nonzero period passes from acceptance through difference, scaling,
// restoring division (one quotient bit per cycle, velocity and acceleration dividers
// running side by side in each lane) and gain multiply-accumulate to the output
// register, loaded once that register is free. A zero-period item goes straight to
// the output register once it is free. One item is in work at a time; the next is
// accepted as soon as the previous result is loaded into the output register. Gains
// are to be written through the cfg port while idle; the block does not enforce this.
`default_nettype none
`include "trajectory_feedforward_assert.svh"

module trajectory_feedforward #(
	parameter int AXES = tff_pkg::AXES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // setpoint_axis0, setpoint_axis1, period_ms
	input  wire logic        s_tuser,   // restart
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // drive_axis0, drive_axis1
	output logic [1:0]       m_tuser,   // status
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_ZERO = 3'b100
	} state_t;

	localparam int PW = tff_pkg::PER_W;

	state_t                  state_q;
	logic [PW-1:0]           per_q;
	logic [2*PW-1:0]         per_sq_q;
	logic signed [31:0]      gain_q [tff_pkg::NAX][3];
	tff_pkg::lane_ctl_t      lane_ctl;
	tff_pkg::lane_stat_t     stat [tff_pkg::NAX];
	logic [PW-1:0]           period;
	logic                    accept, load, can_load, all_done, per_zero;

	assign period    = s_tdata[79:64];
	assign per_zero  = (period == '0);
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		all_done = 1'b1;
		for (int a = 0; a < tff_pkg::NAX; a++) begin
			all_done = all_done & stat[a].done;
		end
	end

	assign load = can_load && (((state_q == ST_RUN) && all_done) || (state_q == ST_ZERO));

	always_comb begin
		lane_ctl.start = accept && !per_zero;
		lane_ctl.clear = accept && s_tuser;
		lane_ctl.take  = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= per_zero ? ST_ZERO : ST_RUN;
					end
				end
				ST_RUN, ST_ZERO: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			per_q    <= period;
			per_sq_q <= (2*PW)'(period) * (2*PW)'(period);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < tff_pkg::NAX; a++) begin
				for (int k = 0; k < 3; k++) begin
					gain_q[a][k] <= '0;
				end
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				tff_pkg::CFG_POS_AX0: gain_q[0][0] <= cfg_data;
				tff_pkg::CFG_VEL_AX0: gain_q[0][1] <= cfg_data;
				tff_pkg::CFG_ACC_AX0: gain_q[0][2] <= cfg_data;
				tff_pkg::CFG_POS_AX1: gain_q[1][0] <= cfg_data;
				tff_pkg::CFG_VEL_AX1: gain_q[1][1] <= cfg_data;
				tff_pkg::CFG_ACC_AX1: gain_q[1][2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	for (genvar a = 0; a < tff_pkg::NAX; a++) begin : g_lane
		if (a < AXES) begin : g_on
			tff_lane u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (lane_ctl),
				.setpoint (s_tdata[a*32 +: 32]),
				.gain_pos (gain_q[a][0]),
				.gain_vel (gain_q[a][1]),
				.gain_acc (gain_q[a][2]),
				.per      (per_q),
				.per_sq   (per_sq_q),
				.stat     (stat[a])
			);
		end else begin : g_off
			// unused axis drives zero and never holds up the merge
			assign stat[a] = '{done: 1'b1, sat: 1'b0, drive: '0};
		end
	end

	tff_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.zero     (state_q == ST_ZERO),
		.stat     (stat),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.can_load (can_load)
	);

	`TFF_ASSERT_NXT(a_accept_leaves_idle, accept, state_q != ST_IDLE, "accepted item left block idle")
	`TFF_ASSERT_NXT(a_zero_period_path, accept && per_zero, state_q == ST_ZERO, "zero period not flagged")
	`TFF_ASSERT_NXT(a_load_shows_result, load, m_tvalid, "loaded result not presented")
	`TFF_ASSERT_IMP(a_take_only_done, lane_ctl.take && (state_q == ST_RUN), all_done, "lanes taken before done")

endmodule

`default_nettype wire
